[sv/tsc_pkg.sv]
// Shared types, constants and prefix tables for the TCP segment classifier.
// No dependencies; every module of the block imports this package.
package tsc_pkg;

  // Segment byte counter saturates here
  localparam int unsigned MAX_SEG_BYTES = 65535;
  localparam int CNT_W = 16;

  // Header and payload prefix capture
  localparam int HDR_KEEP  = 16;
  localparam int HDR_IDX_W = $clog2(HDR_KEEP);
  localparam int PFX_KEEP  = 8;
  localparam int PFX_IDX_W = $clog2(PFX_KEEP);
  localparam int MIN_HDR   = 20;

  // Segment record queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_TRUNC  = 2'd1;
  localparam logic [1:0] ST_BADHDR = 2'd2;

  // Application classes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_DNS  = 2'd1;
  localparam logic [1:0] CLS_HTTP = 2'd2;
  localparam logic [1:0] CLS_TLS  = 2'd3;

  // Well-known ports
  localparam logic [15:0] PORT_DNS    = 16'd53;
  localparam logic [15:0] PORT_HTTP   = 16'd80;
  localparam logic [15:0] PORT_HTTP_A = 16'd8080;
  localparam logic [15:0] PORT_HTTP_B = 16'd8000;
  localparam logic [15:0] PORT_TLS    = 16'd443;
  localparam logic [15:0] PORT_TLS_A  = 16'd8443;

  // TLS record header limits
  localparam logic [7:0]  TLS_TYPE_LO = 8'h14;
  localparam logic [7:0]  TLS_TYPE_HI = 8'h17;
  localparam logic [15:0] TLS_VER_LO  = 16'h0301;
  localparam logic [15:0] TLS_VER_HI  = 16'h0304;
  localparam logic [15:0] TLS_MIN_LEN = 16'd5;

  // HTTP method prefixes, first byte in the top byte, zero padded
  localparam int N_METHODS = 8;
  localparam logic [63:0] METHOD_TEXT [N_METHODS] = '{
    {"GET ", 32'h0},
    {"POST", 32'h0},
    {"HEAD ", 24'h0},
    {"PUT ", 32'h0},
    {"DELETE ", 8'h0},
    "OPTIONS ",
    {"PATCH ", 16'h0},
    {"HTTP/", 24'h0}
  };
  localparam int unsigned METHOD_LEN [N_METHODS] = '{4, 4, 5, 4, 7, 8, 6, 5};

  // One input transfer
  typedef struct packed {
    logic [7:0] seg_byte;
    logic       is_last;
  } in_item_t;

  // One result transfer
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] sequence_res;
    logic [31:0] acknowledge;
    logic [15:0] window_size;
    logic [7:0]  flag_bits;
    logic [5:0]  header_bytes;
    logic [15:0] payload_bytes;
    logic [1:0]  app_class;
    logic [15:0] dns_length;
  } out_item_t;

  // Captured segment handed from front to back
  typedef struct packed {
    logic [HDR_KEEP-1:0][7:0] hdr;
    logic [PFX_KEEP-1:0][7:0] pfx;
    logic [CNT_W-1:0]         size;
  } seg_rec_t;

  // Payload starts with one of the method prefixes and is long enough for it
  function automatic logic http_prefix(logic [PFX_KEEP-1:0][7:0] pfx,
                                       logic [CNT_W-1:0] plen);
    logic [63:0] word;
    logic [63:0] mask;
    logic        hit;
    for (int k = 0; k < PFX_KEEP; k++) begin
      word[63-8*k -: 8] = pfx[k];
    end
    hit = 1'b0;
    for (int m = 0; m < N_METHODS; m++) begin
      mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * METHOD_LEN[m]));
      if ((plen >= CNT_W'(METHOD_LEN[m])) && ((word & mask) == METHOD_TEXT[m])) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

[sv/tsc_front.sv]
// Front end: counts segment bytes, captures header and payload prefix bytes,
// and pushes one segment record per final byte. Depends on tsc_pkg.
module tsc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  tsc_pkg::in_item_t  in_data,
  output logic               in_full,
  output logic               rec_push,
  output tsc_pkg::seg_rec_t  rec_data,
  input  logic               rec_full
);
  import tsc_pkg::*;

  logic [CNT_W-1:0]         cnt_r, cnt_nxt, cnt_inc, poff;
  logic [HDR_KEEP-1:0][7:0] hdr_r, hdr_nxt;
  logic [PFX_KEEP-1:0][7:0] pfx_r, pfx_nxt;
  logic [5:0]               hlen;
  logic                     accept;

  // A byte is taken only when the record queue has room for a possible final byte
  assign in_full = rec_full;
  assign accept  = in_push & ~rec_full;

  // Capture and count
  always_comb begin
    hdr_nxt = hdr_r;
    pfx_nxt = pfx_r;
    hlen    = {hdr_r[12][7:4], 2'b00};
    poff    = cnt_r - CNT_W'(hlen);
    if (cnt_r < CNT_W'(HDR_KEEP)) begin
      hdr_nxt[cnt_r[HDR_IDX_W-1:0]] = in_data.seg_byte;
    end
    if ((cnt_r >= CNT_W'(MIN_HDR)) && (hlen >= 6'(MIN_HDR)) &&
        (cnt_r >= CNT_W'(hlen)) && (poff < CNT_W'(PFX_KEEP))) begin
      pfx_nxt[poff[PFX_IDX_W-1:0]] = in_data.seg_byte;
    end
    cnt_inc = (cnt_r < CNT_W'(MAX_SEG_BYTES)) ? cnt_r + CNT_W'(1) : cnt_r;
    cnt_nxt = in_data.is_last ? '0 : cnt_inc;
  end

  // Record includes the final byte itself
  assign rec_push      = accept & in_data.is_last;
  assign rec_data.hdr  = hdr_nxt;
  assign rec_data.pfx  = pfx_nxt;
  assign rec_data.size = cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Capture bytes need no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_r <= hdr_nxt;
      pfx_r <= pfx_nxt;
    end
  end

endmodule

[sv/tsc_fifo.sv]
// Short queue of segment records between front and back.
// Depends on tsc_pkg for the record type and depth.
module tsc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tsc_pkg::seg_rec_t  wdata,
  output logic               full,
  input  logic               pop,
  output tsc_pkg::seg_rec_t  rdata,
  output logic               empty
);
  import tsc_pkg::*;

  seg_rec_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_wr, do_rd;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = push & ~full;
  assign do_rd = pop & ~empty;
  assign rdata = mem_r[rd_ptr_r];

  // Pointer and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("record queue occupancy above depth");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !pop) |=> (cnt_r == $past(cnt_r) + QCNT_W'(1)))
    else $error("record queue lost a transfer");

  a_cnt_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !push) |=> (cnt_r == $past(cnt_r) - QCNT_W'(1)))
    else $error("record queue pop did not drain");

endmodule

[sv/tsc_back.sv]
// Back end: decodes a segment record into header fields, lengths and an
// application class, and holds the result in the output register. Depends on tsc_pkg.
module tsc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tsc_pkg::seg_rec_t  rec_data,
  input  logic               rec_empty,
  output logic               rec_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output tsc_pkg::out_item_t out_data
);
  import tsc_pkg::*;

  out_item_t        res, res_r;
  logic             valid_r, load;
  logic [15:0]      sp, dp, dlen, tls_ver;
  logic [5:0]       hlen;
  logic [CNT_W-1:0] plen;
  logic             is_dns, hp, tp, tls_rec;

  // Refill the output register when empty or being drained
  assign load    = ~rec_empty & (~valid_r | out_pop);
  assign rec_pop = load;

  // Classification
  always_comb begin
    sp      = {rec_data.hdr[0], rec_data.hdr[1]};
    dp      = {rec_data.hdr[2], rec_data.hdr[3]};
    hlen    = {rec_data.hdr[12][7:4], 2'b00};
    plen    = rec_data.size - CNT_W'(hlen);
    dlen    = {rec_data.pfx[0], rec_data.pfx[1]};
    tls_ver = {rec_data.pfx[1], rec_data.pfx[2]};
    is_dns  = ((sp == PORT_DNS) || (dp == PORT_DNS)) && (plen > CNT_W'(2)) &&
              (({1'b0, dlen} + 17'd2) <= {1'b0, plen});
    hp      = (sp == PORT_HTTP) || (dp == PORT_HTTP) || (sp == PORT_HTTP_A) ||
              (dp == PORT_HTTP_A) || (sp == PORT_HTTP_B) || (dp == PORT_HTTP_B);
    tp      = (sp == PORT_TLS) || (dp == PORT_TLS) || (sp == PORT_TLS_A) ||
              (dp == PORT_TLS_A);
    tls_rec = (plen >= TLS_MIN_LEN) &&
              (rec_data.pfx[0] >= TLS_TYPE_LO) && (rec_data.pfx[0] <= TLS_TYPE_HI) &&
              (tls_ver >= TLS_VER_LO) && (tls_ver <= TLS_VER_HI);

    res = '0;
    if (rec_data.size < CNT_W'(MIN_HDR)) begin
      res.status = ST_TRUNC;
    end else begin
      res.source_port  = sp;
      res.dest_port    = dp;
      res.sequence_res = {rec_data.hdr[4], rec_data.hdr[5], rec_data.hdr[6], rec_data.hdr[7]};
      res.acknowledge  = {rec_data.hdr[8], rec_data.hdr[9], rec_data.hdr[10],
                          rec_data.hdr[11]};
      res.window_size  = {rec_data.hdr[14], rec_data.hdr[15]};
      res.flag_bits    = rec_data.hdr[13];
      res.header_bytes = hlen;
      if ((hlen < 6'(MIN_HDR)) || (CNT_W'(hlen) > rec_data.size)) begin
        res.status = ST_BADHDR;
      end else begin
        res.status        = ST_OK;
        res.payload_bytes = plen;
        if (plen != '0) begin
          if (is_dns) begin
            res.app_class  = CLS_DNS;
            res.dns_length = dlen;
          end else if (hp || http_prefix(rec_data.pfx, plen)) begin
            res.app_class = CLS_HTTP;
          end else if (tp || tls_rec) begin
            res.app_class = CLS_TLS;
          end else begin
            res.app_class = CLS_NONE;
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_empty = ~valid_r;
  assign out_data  = res_r;

endmodule

[sv/tcp_segment_classifier.sv]
// Top level of the TCP segment classifier: front end, record queue, back end.
// Depends on tsc_pkg, tsc_front, tsc_fifo and tsc_back.
//
// Usage:
//   Input channel: push one segment byte per cycle on in_data with in_push;
//   the transfer happens when in_full is low. in_data.is_last marks the final
//   byte of a segment. Bytes of the next segment may follow in the next cycle.
//   Result channel: one result per segment, oldest first. It is on out_data
//   while out_empty is low and leaves on a cycle with out_pop high.
// Path: the final byte's transfer writes its record into the record queue,
//   and the output register loads it when empty or being popped; out_data
//   is driven straight from that register.
// Throughput: one byte per cycle while in_full is low; even one-byte
//   segments run at full rate while results are popped.
// Stall: if results are not popped, the output register and the two-entry
//   record queue fill; in_full then rises and holds all further bytes.
// Reset: rst_n low clears the byte count, the queue and the output valid
//   flag; a partly received segment is discarded.
module tcp_segment_classifier (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  tsc_pkg::in_item_t  in_data,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output tsc_pkg::out_item_t out_data
);
  import tsc_pkg::*;

  seg_rec_t wr_rec, rd_rec;
  logic     rec_push, rec_full, rec_pop, rec_empty;

  tsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .rec_push (rec_push),
    .rec_data (wr_rec),
    .rec_full (rec_full)
  );

  tsc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .wdata (wr_rec),
    .full  (rec_full),
    .pop   (rec_pop),
    .rdata (rd_rec),
    .empty (rec_empty)
  );

  tsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_data  (rd_rec),
    .rec_empty (rec_empty),
    .rec_pop   (rec_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
